/* rtl/trace_ring_buffer_top_macros.svh */
// Assertion macros shared by the trace ring buffer RTL.
// Depends on clk_i and rst_ni being visible in the module that uses them.
`ifndef TRACE_RING_BUFFER_TOP_MACROS_SVH
`define TRACE_RING_BUFFER_TOP_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define TRB_ASSERT_SAME(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define TRB_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/trb_pkg.sv */
// Shared constants and types for the trace ring buffer.
// No dependencies; used by trb_ram and trace_ring_buffer_top.
package trb_pkg;

  localparam int RING_DEPTH_DEF = 16384;
  localparam int SIZE_W         = 15;
  localparam int ARITH_W        = 18;
  localparam int DATA_W         = 8;

  localparam logic [SIZE_W-1:0] RING_SIZE_RESET = 15'd2048;
  localparam logic [SIZE_W-1:0] RING_SIZE_MIN   = 15'd2;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

endpackage

/* rtl/trb_ram.sv */
// Byte store of the trace ring: one write port, one registered read port.
// Depends on trb_pkg for the data width.
module trb_ram #(
  parameter int DEPTH  = trb_pkg::RING_DEPTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [ADDR_W-1:0]         wr_addr_i,
  input  logic [trb_pkg::DATA_W-1:0] wr_data_i,
  input  logic                      rd_en_i,
  input  logic [ADDR_W-1:0]         rd_addr_i,
  output logic [trb_pkg::DATA_W-1:0] rd_data_o
);

  logic [trb_pkg::DATA_W-1:0] mem [DEPTH];
  logic [trb_pkg::DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read data holds until the next read enable, so a stalled consumer keeps it.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/trace_ring_buffer_top.sv */
// Trace ring buffer: overwriting byte ring for log capture, built on trb_ram and trb_pkg.
// An accepted request is registered in stage B and then in the output register, stage C.
// Throughput: one request per cycle unless the output stalls, with one store write and read port.
// Reset (rst_ni low, asynchronous) empties the pipeline, clears head, wrap flag and counters,
// and sets the ring size to 2048; the byte store itself is not cleared and holds garbage.
`include "trace_ring_buffer_top_macros.svh"

module trace_ring_buffer_top #(
  parameter int RING_DEPTH = trb_pkg::RING_DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration: ring size in bytes.
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [14:0]  cfg_data_i,
  // Request stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [7:0] data_byte, [22:8] want_bytes, [38:23] back_offset, [53:39] capacity,
  // [67:54] byte_index, [71:68] zero
  input  logic [71:0]  s_axis_tdata,
  input  logic         s_axis_tlast,   // message_end
  input  logic [1:0]   s_axis_tuser,   // action
  // Result stream.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [7:0] read_data, [22:8] read_count, [37:23] held_bytes, [69:38] written_total,
  // [101:70] dropped_total, [103:102] zero
  output logic [103:0] m_axis_tdata
);

  localparam int ADDR_W   = $clog2(RING_DEPTH);
  localparam int SIZE_W   = trb_pkg::SIZE_W;
  localparam int ARITH_W  = trb_pkg::ARITH_W;
  localparam int DATA_W   = trb_pkg::DATA_W;
  // Largest usable size: bounded by the memory and by the 15-bit register.
  localparam int SIZE_MAX = (RING_DEPTH < 32767) ? RING_DEPTH : 32767;

  // Stage B holds a read whose window is known; the address is formed there.
  typedef struct packed {
    logic               rd_hit;
    logic [ARITH_W-1:0] e_pos;     // window end position (exclusive) in the ring
    logic [ARITH_W-1:0] n_len;     // clamped window length
    logic [13:0]        idx;
    logic [SIZE_W-1:0]  rcount;
    logic [SIZE_W-1:0]  held;
    logic [31:0]        written;
    logic [31:0]        dropped;
  } stage_b_t;

  // Stage C is the output register; the byte comes from the store's read register.
  typedef struct packed {
    logic              rd_hit;
    logic [SIZE_W-1:0] rcount;
    logic [SIZE_W-1:0] held;
    logic [31:0]       written;
    logic [31:0]       dropped;
  } stage_c_t;

  // ------------------------------------------------------------------
  // Request fields
  // ------------------------------------------------------------------
  trb_pkg::action_e    action;
  logic [DATA_W-1:0]   data_byte;
  logic [14:0]         want_bytes;
  logic [15:0]         back_offset;
  logic [14:0]         capacity;
  logic [13:0]         byte_index;

  assign action      = trb_pkg::action_e'(s_axis_tuser);
  assign data_byte   = s_axis_tdata[7:0];
  assign want_bytes  = s_axis_tdata[22:8];
  assign back_offset = s_axis_tdata[38:23];
  assign capacity    = s_axis_tdata[53:39];
  assign byte_index  = s_axis_tdata[67:54];

  // ------------------------------------------------------------------
  // Ring state
  // ------------------------------------------------------------------
  logic [ADDR_W-1:0] head_q, head_d;
  logic              wrapped_q, wrapped_d;
  logic [31:0]       written_q, written_d;
  logic [31:0]       dropped_q, dropped_d;
  logic [SIZE_W-1:0] size_q, size_d;

  logic b_valid_q, c_valid_q;
  stage_b_t b_q, b_d;
  stage_c_t c_q;

  logic advance, s_accept, cfg_accept;

  // The whole pipeline moves together whenever the output register can take a result.
  // The message_end flag is accepted with the request but never changes the state.
  assign advance       = !c_valid_q || m_axis_tready;
  assign s_axis_tready = advance;
  assign s_accept      = s_axis_tvalid && advance && (s_axis_tlast || !s_axis_tlast);
  assign cfg_ready_o   = 1'b1;
  assign cfg_accept    = cfg_valid_i;

  // The configured size is clamped once at write time, so the rest of the logic
  // always sees a legal size.
  logic [SIZE_W-1:0] cfg_size;
  always_comb begin
    if (cfg_data_i < trb_pkg::RING_SIZE_MIN) begin
      cfg_size = trb_pkg::RING_SIZE_MIN;
    end else if (32'(cfg_data_i) > 32'(SIZE_MAX)) begin
      cfg_size = SIZE_W'(SIZE_MAX);
    end else begin
      cfg_size = cfg_data_i;
    end
  end

  // ------------------------------------------------------------------
  // Stage A: state update for pushes, clears and size writes, window clamp for reads
  // ------------------------------------------------------------------
  logic [ARITH_W-1:0] head_w, size_w, back_w, want_w, cap_w;
  logic [ARITH_W-1:0] head_inc, held_cur, rem, n_want, n_len, e_pos;
  logic               win_hit, idx_hit;

  assign head_w   = ARITH_W'(head_q);
  assign size_w   = ARITH_W'(size_q);
  assign back_w   = ARITH_W'(back_offset);
  assign want_w   = ARITH_W'(want_bytes);
  assign cap_w    = ARITH_W'(capacity);
  assign head_inc = head_w + ARITH_W'(1);
  assign held_cur = wrapped_q ? size_w : head_w;

  // The window ends back_offset bytes before the head and holds at most what is
  // still behind that point, the request, and the reader capacity.
  always_comb begin
    win_hit = (back_w < held_cur) && (capacity != '0);
    rem     = held_cur - back_w;
    n_want  = ((want_bytes == '0) || (want_w > rem)) ? rem : want_w;
    n_len   = (n_want > cap_w) ? cap_w : n_want;
    if (!win_hit) begin
      n_len = '0;
    end
    // Window end wraps around by one ring size when the offset passes the head.
    if (head_w >= back_w) begin
      e_pos = head_w - back_w;
    end else begin
      e_pos = head_w + size_w - back_w;
    end
    idx_hit = ARITH_W'(byte_index) < n_len;
  end

  always_comb begin
    head_d    = head_q;
    wrapped_d = wrapped_q;
    written_d = written_q;
    dropped_d = dropped_q;
    size_d    = size_q;
    if (s_accept) begin
      unique case (action)
        trb_pkg::ACT_PUSH: begin
          if (head_inc >= size_w) begin
            head_d    = '0;
            wrapped_d = 1'b1;
          end else begin
            head_d = ADDR_W'(head_inc);
          end
          written_d = written_q + 32'd1;
          // After the 32-bit count wraps, dropped keeps its value until the
          // count climbs past the size again.
          if (wrapped_d && (written_d > 32'(size_q))) begin
            dropped_d = written_d - 32'(size_q);
          end
        end
        trb_pkg::ACT_CLEAR: begin
          head_d    = '0;
          wrapped_d = 1'b0;
          written_d = '0;
          dropped_d = '0;
        end
        default: begin
          // Reads leave the pointers alone; the unused code does nothing.
        end
      endcase
    end
    // A size change restarts the ring so the head stays below the size.
    if (cfg_accept) begin
      size_d    = cfg_size;
      head_d    = '0;
      wrapped_d = 1'b0;
      written_d = '0;
      dropped_d = '0;
    end
  end

  // The reported held count, written and dropped totals follow the action.
  always_comb begin
    b_d.rd_hit  = (action == trb_pkg::ACT_READ) && win_hit && idx_hit;
    b_d.e_pos   = e_pos;
    b_d.n_len   = n_len;
    b_d.idx     = byte_index;
    b_d.rcount  = (action == trb_pkg::ACT_READ) ? SIZE_W'(n_len) : '0;
    b_d.held    = wrapped_d ? size_q : SIZE_W'(head_d);
    b_d.written = written_d;
    b_d.dropped = dropped_d;
  end

  // ------------------------------------------------------------------
  // Stage B: byte address inside the window, store read
  // ------------------------------------------------------------------
  logic [ARITH_W-1:0] pos_sum, rd_pos;
  logic               ram_rd_en, ram_wr_en;
  logic [DATA_W-1:0]  ram_rd_data;

  // Position is end - length + index; it falls below zero at most once.
  assign pos_sum   = b_q.e_pos + ARITH_W'(b_q.idx);
  assign rd_pos    = (pos_sum < b_q.n_len) ? (pos_sum + size_w - b_q.n_len)
                                           : (pos_sum - b_q.n_len);
  assign ram_rd_en = advance && b_valid_q && b_q.rd_hit;
  // A push writes at the edge that accepts it. A read ahead of it in stage B reads
  // at the same edge and sees the old byte; a read behind it reads a later edge.
  assign ram_wr_en = s_accept && (action == trb_pkg::ACT_PUSH);

  trb_ram #(
    .DEPTH  (RING_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (head_q),
    .wr_data_i (data_byte),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ADDR_W'(rd_pos)),
    .rd_data_o (ram_rd_data)
  );

  // ------------------------------------------------------------------
  // Registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      wrapped_q <= 1'b0;
      written_q <= '0;
      dropped_q <= '0;
      size_q    <= trb_pkg::RING_SIZE_RESET;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      head_q    <= head_d;
      wrapped_q <= wrapped_d;
      written_q <= written_d;
      dropped_q <= dropped_d;
      size_q    <= size_d;
      if (advance) begin
        b_valid_q <= s_accept;
        c_valid_q <= b_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      b_q        <= b_d;
      c_q.rd_hit  <= b_q.rd_hit;
      c_q.rcount  <= b_q.rcount;
      c_q.held    <= b_q.held;
      c_q.written <= b_q.written;
      c_q.dropped <= b_q.dropped;
    end
  end

  // ------------------------------------------------------------------
  // Output
  // ------------------------------------------------------------------
  logic [DATA_W-1:0] read_data;

  // An index outside the window, or any non-read request, returns a zero byte.
  assign read_data     = c_q.rd_hit ? ram_rd_data : '0;
  assign m_axis_tvalid = c_valid_q;
  assign m_axis_tdata  = {2'b00, c_q.dropped, c_q.written, c_q.held, c_q.rcount, read_data};

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  `TRB_ASSERT_SAME(a_head_below_size, 1'b1, ARITH_W'(head_q) < ARITH_W'(size_q), "head not below ring size")
  `TRB_ASSERT_SAME(a_no_drop_unwrapped, !wrapped_q, dropped_q == '0, "bytes dropped before wrap")
  `TRB_ASSERT_SAME(a_empty_window_zero, m_axis_tvalid && (m_axis_tdata[22:8] == '0), m_axis_tdata[7:0] == '0, "byte returned from an empty window")

endmodule

/* tb/tb_trace_ring_buffer_top.sv */
// Self-checking testbench for trace_ring_buffer_top: random and directed requests with a
// scoreboard class that predicts each result. Depends on trb_pkg and the trace ring buffer RTL.
module tb_trace_ring_buffer_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RING_DEPTH  = trb_pkg::RING_DEPTH_DEF;
  localparam logic [1:0]  ACT_SPARE   = 2'd3;   // unused action code, must change nothing
  localparam int          RANDOM_PER_PHASE = 100;
  localparam int          FILL_PUSHES = 150;
  // The limit covers the slowest legal run, with every request behind a long gap and a long
  // result stall.
  localparam int          CYCLE_LIMIT = 1_000_000;

  // One request as the block sees it; tuser carries the action, tlast the message end.
  typedef struct {
    bit [1:0]  action;
    bit [7:0]  data_byte;
    bit        message_end;
    bit [14:0] want_bytes;
    bit [15:0] back_offset;
    bit [14:0] capacity;
    bit [13:0] byte_index;
  } request_t;

  typedef struct {
    bit [7:0]  read_data;
    bit [14:0] read_count;
    bit [14:0] held_bytes;
    bit [31:0] written_total;
    bit [31:0] dropped_total;
  } ring_result_t;

  // Predicts the ring state after every accepted request and checks the result stream
  // against the queue of predicted results, oldest first.
  class ring_scoreboard;
    bit [7:0]     ring_mem [RING_DEPTH];
    int unsigned  head;
    bit           wrapped;
    bit [31:0]    written;
    bit [31:0]    dropped;
    bit [14:0]    size_reg;
    ring_result_t predicted_q[$];
    int unsigned  mismatches, results_seen;
    int unsigned  pushes, reads, byte_hits, clears, spares, size_writes;

    function new();
      size_reg = trb_pkg::RING_SIZE_RESET;
      clear_counters();
    endfunction

    function void clear_counters();
      head    = 0;
      wrapped = 1'b0;
      written = '0;
      dropped = '0;
    endfunction

    // Register values outside the legal range are clamped, not rejected.
    function int unsigned size_in_use();
      if (size_reg < 2) return 2;
      if (32'(size_reg) > RING_DEPTH) return RING_DEPTH;
      return 32'(size_reg);
    endfunction

    function int unsigned held_now();
      return wrapped ? size_in_use() : head;
    endfunction

    function void write_size(bit [14:0] value);
      size_reg = value;
      size_writes++;
      clear_counters();
    endfunction

    function int pending();
      return predicted_q.size();
    endfunction

    function void note_request(request_t r);
      ring_result_t res;
      int unsigned  sz, held, n, start, pos, nxt;
      sz  = size_in_use();
      res = '{default: '0};
      case (r.action)
        trb_pkg::ACT_PUSH: begin
          pushes++;
          ring_mem[head] = r.data_byte;
          nxt = head + 1;
          if (nxt >= sz) begin
            nxt     = 0;
            wrapped = 1'b1;
          end
          head    = nxt;
          written = written + 32'd1;
          // After the 32-bit count wraps, the dropped count holds until it passes the size.
          if (wrapped && written > 32'(sz)) dropped = written - 32'(sz);
        end
        trb_pkg::ACT_READ: begin
          reads++;
          held = held_now();
          if (32'(r.back_offset) < held && r.capacity != 0) begin
            held = held - 32'(r.back_offset);
            n    = 32'(r.want_bytes);
            if (n == 0 || n > held) n = held;
            if (n > 32'(r.capacity)) n = 32'(r.capacity);
            start = head + 2 * sz - 32'(r.back_offset) - n;
            if (start >= sz) start -= sz;
            if (start >= sz) start -= sz;
            res.read_count = 15'(n);
            if (32'(r.byte_index) < n) begin
              pos = start + 32'(r.byte_index);
              if (pos >= sz) pos -= sz;
              res.read_data = ring_mem[pos];
              byte_hits++;
            end
          end
        end
        trb_pkg::ACT_CLEAR: begin
          clears++;
          clear_counters();
        end
        default: spares++;
      endcase
      res.held_bytes    = 15'(held_now());
      res.written_total = written;
      res.dropped_total = dropped;
      predicted_q.push_back(res);
    endfunction

    function void check_result(logic [103:0] d);
      ring_result_t exp_res;
      results_seen++;
      if (predicted_q.size() == 0) begin
        $error("result arrived with no request outstanding");
        mismatches++;
        return;
      end
      exp_res = predicted_q.pop_front();
      if (d[7:0] !== exp_res.read_data) begin
        $error("read_data: expected %0d, got %0d", exp_res.read_data, d[7:0]);
        mismatches++;
      end
      if (d[22:8] !== exp_res.read_count) begin
        $error("read_count: expected %0d, got %0d", exp_res.read_count, d[22:8]);
        mismatches++;
      end
      if (d[37:23] !== exp_res.held_bytes) begin
        $error("held_bytes: expected %0d, got %0d", exp_res.held_bytes, d[37:23]);
        mismatches++;
      end
      if (d[69:38] !== exp_res.written_total) begin
        $error("written_total: expected %0d, got %0d", exp_res.written_total, d[69:38]);
        mismatches++;
      end
      if (d[101:70] !== exp_res.dropped_total) begin
        $error("dropped_total: expected %0d, got %0d", exp_res.dropped_total, d[101:70]);
        mismatches++;
      end
    endfunction
  endclass

  logic          clk_i;
  logic          rst_ni        = 1'b0;
  logic          cfg_valid_i   = 1'b0;
  logic          cfg_ready_o;
  logic [14:0]   cfg_data_i    = '0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [71:0]   s_axis_tdata  = '0;
  logic          s_axis_tlast  = 1'b0;
  logic [1:0]    s_axis_tuser  = trb_pkg::ACT_PUSH;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [103:0]  m_axis_tdata;

  ring_scoreboard sb = new();

  // Set while the ring is being filled back to back.
  bit          no_gaps   = 1'b0;
  int unsigned calm_left = 0;

  trace_ring_buffer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Gap before the next request: mostly none, some short, a few long, and now and then
  // a run of requests sent back to back.
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm_left = $urandom_range(20, 100);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic request_t make_request(bit [1:0] action, bit [7:0] data_byte,
                                            bit message_end, bit [14:0] want_bytes,
                                            bit [15:0] back_offset, bit [14:0] capacity,
                                            bit [13:0] byte_index);
    request_t r;
    r.action      = action;
    r.data_byte   = data_byte;
    r.message_end = message_end;
    r.want_bytes  = want_bytes;
    r.back_offset = back_offset;
    r.capacity    = capacity;
    r.byte_index  = byte_index;
    return r;
  endfunction

  // Reads are mostly shaped around the bytes now held, so that windows land inside the
  // ring; the rest use the full field ranges. Every field keeps random content.
  function automatic request_t random_request();
    request_t    r;
    int unsigned held, pick;
    held          = sb.held_now();
    pick          = $urandom_range(0, 99);
    r.data_byte   = 8'($urandom_range(0, 255));
    r.message_end = 1'($urandom_range(0, 1));
    r.want_bytes  = 15'($urandom_range(0, 32767));
    r.back_offset = 16'($urandom_range(0, 65535));
    r.capacity    = 15'($urandom_range(0, 32767));
    r.byte_index  = 14'($urandom_range(0, 16383));
    if (pick < 55) begin
      r.action = trb_pkg::ACT_PUSH;
    end else if (pick < 92) begin
      r.action = trb_pkg::ACT_READ;
      pick = $urandom_range(0, 9);
      if (pick < 6) r.back_offset = 16'($urandom_range(0, held + 1));
      else if (pick < 7) r.back_offset = (held == 0) ? 16'd0 : 16'(held - $urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      if (pick < 2) r.want_bytes = 15'd0;
      else if (pick < 6) r.want_bytes = 15'($urandom_range(1, held + 2));
      pick = $urandom_range(0, 19);
      if (pick == 0) r.capacity = 15'd0;
      else if (pick < 10) r.capacity = 15'($urandom_range(1, held + 2));
      if ($urandom_range(0, 9) < 6) begin
        r.byte_index = 14'($urandom_range(0, (held < 16383) ? held : 16383));
      end
    end else if (pick < 96) begin
      r.action = trb_pkg::ACT_CLEAR;
    end else begin
      r.action = ACT_SPARE;
    end
    return r;
  endfunction

  // Presents one request, starting at a falling edge, and returns at the falling edge after
  // its acceptance with tvalid still high, so a following request can go out without a gap.
  task automatic send_request(request_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {4'b0, r.byte_index, r.capacity, r.back_offset, r.want_bytes,
                      r.data_byte};
    s_axis_tlast  <= r.message_end;
    s_axis_tuser  <= r.action;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(r);
    @(negedge clk_i);
  endtask

  // Holds back the sender until every predicted result has come out of the block.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // The ring size may only change while the block is idle; the pause after the drain
  // covers the depth of the block's pipeline.
  task automatic write_ring_size(bit [14:0] value);
    drain_results();
    repeat (4) @(negedge clk_i);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_size(value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      send_request(random_request());
      if ($urandom_range(0, 199) == 0) drain_results();
    end
  endtask

  // Result side: ready is held high or low for random stretches, low mostly briefly.
  initial begin : result_stall
    int hold;
    int r;
    bit rdy;
    hold = 0;
    rdy  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold == 0) begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          rdy  = 1'b1;
          hold = $urandom_range(1, 40);
        end else if (r < 95) begin
          rdy  = 1'b0;
          hold = $urandom_range(1, 3);
        end else begin
          rdy  = 1'b0;
          hold = $urandom_range(8, 30);
        end
      end
      hold--;
      m_axis_tready <= rdy;
    end
  end

  // Every accepted result is checked at the edge that takes it.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    request_t    directed_q[$];
    int unsigned size_plan[$];
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part at the reset size: empty ring, byte extremes, window clamping,
    // an offset that reaches the held bytes, zero capacity, the unused action and clear.
    directed_q = '{
      make_request(trb_pkg::ACT_READ, 8'h00, 1'b0, 15'd0, 16'd0, 15'd16384, 14'd0),
      make_request(trb_pkg::ACT_PUSH, 8'h00, 1'b0, 15'd0, 16'd0, 15'd0, 14'd0),
      make_request(trb_pkg::ACT_PUSH, 8'hFF, 1'b1, 15'h7FFF, 16'hFFFF, 15'h7FFF, 14'h3FFF),
      make_request(trb_pkg::ACT_PUSH, 8'hA5, 1'b0, 15'd0, 16'd0, 15'd0, 14'd0),
      make_request(trb_pkg::ACT_PUSH, 8'h5A, 1'b1, 15'd0, 16'd0, 15'd0, 14'd0),
      make_request(trb_pkg::ACT_READ, 8'h00, 1'b0, 15'd0, 16'd0, 15'd16384, 14'd0),
      make_request(trb_pkg::ACT_READ, 8'h00, 1'b0, 15'd0, 16'd0, 15'h7FFF, 14'd3),
      make_request(trb_pkg::ACT_READ, 8'h00, 1'b0, 15'd2, 16'd1, 15'd10, 14'd1),
      make_request(trb_pkg::ACT_READ, 8'h00, 1'b0, 15'd0, 16'd0, 15'd16384, 14'h3FFF),
      make_request(trb_pkg::ACT_READ, 8'h00, 1'b0, 15'd0, 16'd4, 15'd16384, 14'd0),
      make_request(trb_pkg::ACT_READ, 8'h00, 1'b0, 15'd0, 16'hFFFF, 15'd16384, 14'd0),
      make_request(trb_pkg::ACT_READ, 8'h00, 1'b0, 15'd0, 16'd0, 15'd0, 14'd0),
      make_request(trb_pkg::ACT_READ, 8'h00, 1'b0, 15'h7FFF, 16'd0, 15'd1, 14'd0),
      make_request(trb_pkg::ACT_READ, 8'h00, 1'b0, 15'd16384, 16'd3, 15'd16384, 14'd0),
      make_request(ACT_SPARE, 8'hFF, 1'b1, 15'h7FFF, 16'hFFFF, 15'h7FFF, 14'h3FFF),
      make_request(trb_pkg::ACT_CLEAR, 8'h00, 1'b0, 15'd0, 16'd0, 15'd0, 14'd0),
      make_request(trb_pkg::ACT_READ, 8'h00, 1'b0, 15'd0, 16'd0, 15'd16384, 14'd0),
      make_request(trb_pkg::ACT_PUSH, 8'h3C, 1'b0, 15'd0, 16'd0, 15'd0, 14'd0),
      make_request(trb_pkg::ACT_READ, 8'hFF, 1'b1, 15'h7FFF, 16'd0, 15'h7FFF, 14'd0)
    };
    foreach (directed_q[i]) send_request(directed_q[i]);
    random_phase(RANDOM_PER_PHASE);

    // Ring sizes: below the minimum, the minimum, small odd sizes, the reset value,
    // the full depth and values above it, then one random size.
    size_plan = '{0, 2, 1, 3, 7, 64, 2048, RING_DEPTH, 32767, RING_DEPTH + 1, 255,
                  $urandom_range(2, 600)};
    foreach (size_plan[i]) begin
      write_ring_size(15'(size_plan[i]));
      if (size_plan[i] == RING_DEPTH) begin
        // Fill the start of the full-depth ring back to back, then read its oldest byte,
        // an index past the window and an offset beyond the held bytes.
        no_gaps = 1'b1;
        for (int k = 0; k < FILL_PUSHES; k++) begin
          send_request(make_request(trb_pkg::ACT_PUSH, 8'($urandom_range(0, 255)),
                                    1'($urandom_range(0, 1)), 15'd0, 16'd0, 15'd0, 14'd0));
        end
        no_gaps = 1'b0;
        send_request(make_request(trb_pkg::ACT_READ, 8'h00, 1'b0, 15'd0, 16'd0, 15'd16384,
                                  14'h3FFF));
        send_request(make_request(trb_pkg::ACT_READ, 8'h00, 1'b0, 15'd0, 16'd0, 15'd16384,
                                  14'd0));
        send_request(make_request(trb_pkg::ACT_READ, 8'h00, 1'b0, 15'd0, 16'd16383, 15'h7FFF,
                                  14'd0));
      end
      random_phase(RANDOM_PER_PHASE);
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (sb.pending() != 0) $error("%0d predicted results never arrived", sb.pending());

    $display("Covered %0d pushes, %0d reads (%0d with a byte), %0d clears, %0d unused codes.",
             sb.pushes, sb.reads, sb.byte_hits, sb.clears, sb.spares);
    $display("Checked %0d results across %0d ring size writes.", sb.results_seen, sb.size_writes);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
